// File: hdl/fptm_pkg.sv
// ----------------------------------------------------------------------------
// fptm_pkg
// Shared types and constants of the fan temperature, PWM and tach monitor.
// ----------------------------------------------------------------------------
package fptm_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] OP_TEMP     = 3'd0;
    localparam logic [2:0] OP_EDGE     = 3'd1;
    localparam logic [2:0] OP_STALL    = 3'd2;
    localparam logic [2:0] OP_TEST_ON  = 3'd3;
    localparam logic [2:0] OP_TEST_OFF = 3'd4;

    localparam logic [2:0] REG_PWM_TOP       = 3'd0;
    localparam logic [2:0] REG_TIMER_TOP     = 3'd1;
    localparam logic [2:0] REG_NUMERATOR     = 3'd2;
    localparam logic [2:0] REG_STALL_LIMIT   = 3'd3;
    localparam logic [2:0] REG_ALARM_INTERVAL = 3'd4;
    localparam logic [2:0] REG_REPORT_ENABLE = 3'd5;

    localparam logic [15:0] PWM_TOP_RESET     = 16'd999;
    localparam logic [15:0] TIMER_TOP_RESET   = 16'd65535;
    localparam logic [31:0] NUMERATOR_RESET   = 32'd1200000;
    localparam logic [31:0] STALL_LIMIT_RESET = 32'd1200;
    localparam logic [31:0] INTERVAL_RESET    = 32'd300000;
    localparam logic [15:0] DUTY_RESET        = PWM_TOP_RESET / 16'd10;

    // 27 C and 30 C in sixteenths of a degree
    localparam logic signed [11:0] TEMP_LOW  = 12'sd432;
    localparam logic signed [11:0] TEMP_HIGH = 12'sd480;
    localparam logic [10:0] CURVE_OFFSET = 11'd1280;
    localparam logic [31:0] CURVE_SPAN   = 32'd160;
    // ceil(2^21 / 5): divide by 160 as ((p >> 5) * CURVE_RECIP) >> 21
    localparam logic [18:0] CURVE_RECIP  = 19'd419431;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [11:0] temp_q4;
        logic               temp_invalid;
        logic [15:0]        capture_value;
        logic [31:0]        now_ms;
    } in_word_t;

    typedef struct packed {
        logic        fan_enable;
        logic [15:0] pwm_compare;
        logic [31:0] tach_freq;
        logic        stall_alarm;
        logic        self_test_active;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic curve_write;
        logic div_start;
        logic div_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

// File: hdl/fan_temperature_pwm_tach_monitor_unit.sv
// ----------------------------------------------------------------------------
// fan_temperature_pwm_tach_monitor_unit
// Fan curve from temperature, tach frequency measurement and stall alarm.
// ----------------------------------------------------------------------------
// Steps: a word is loaded, executed and its result registered; an in-curve
// temperature adds the reciprocal multiply step, and a second tach edge with a
// positive period adds the 32-step divider.
// Throughput: one word at a time, next word taken in the cycle after the
// result is registered, even while that result still waits on m_ready.
// Reset (sync, aresetn low): all but data registers take defaults, no result.
module fan_temperature_pwm_tach_monitor_unit
    import fptm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    fptm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fptm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule

// File: hdl/fptm_div.sv
// ----------------------------------------------------------------------------
// fptm_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fptm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/fptm_dp.sv
// ----------------------------------------------------------------------------
// fptm_dp
// Datapath: configuration registers, fan and tach state, curve multiplier,
// tach divider and result register.
// ----------------------------------------------------------------------------
module fptm_dp
    import fptm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  in_word_t          s_data,
    output out_word_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata
);
    logic [15:0] pwm_top_reg, pwm_top_next;
    logic [15:0] timer_top_reg, timer_top_next;
    logic [31:0] numerator_reg, numerator_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] interval_reg, interval_next;
    logic        report_reg, report_next;

    logic        running_reg, running_next;
    logic [15:0] duty_reg, duty_next;
    logic        self_test_reg, self_test_next;
    logic        capture_on_reg, capture_on_next;
    logic        second_edge_reg, second_edge_next;
    logic [15:0] first_stamp_reg, first_stamp_next;
    logic [31:0] freq_reg, freq_next;
    logic [31:0] mark_reg, mark_next;
    logic        alarm_reg, alarm_next;

    in_word_t    item_reg;
    logic [23:0] prod_reg;
    out_word_t   out_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        temp_below;
    logic        temp_above;
    logic [10:0] temp_x3;
    logic [10:0] curve_diff;
    logic [23:0] prod;
    logic [37:0] curve_prod;
    logic [17:0] period_wrap;
    logic [17:0] period;
    logic        period_pos;
    logic [31:0] mark_base;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    assign temp_below = (item_reg.temp_q4 < TEMP_LOW);
    assign temp_above = (item_reg.temp_q4 > TEMP_HIGH);
    assign temp_x3    = {2'b00, item_reg.temp_q4[8:0]}
                      + {1'b0, item_reg.temp_q4[8:0], 1'b0};
    assign curve_diff = temp_x3 - CURVE_OFFSET;
    assign prod       = curve_diff[7:0] * pwm_top_reg;
    assign curve_prod = {19'd0, prod_reg[23:5]} * {19'd0, CURVE_RECIP};

    assign period_wrap = {2'b00, item_reg.capture_value} + {2'b00, timer_top_reg}
                       + 18'd1 - {2'b00, first_stamp_reg};
    assign period      = (first_stamp_reg > item_reg.capture_value)
                       ? period_wrap
                       : ({2'b00, item_reg.capture_value} - {2'b00, first_stamp_reg});
    assign period_pos  = !period[17] && (period != 18'd0);

    assign mark_base = report_reg ? mark_reg : item_reg.now_ms;

    assign status.need_mul = (item_reg.opcode == OP_TEMP) && !self_test_reg
                           && !item_reg.temp_invalid && !temp_below && !temp_above;
    assign status.need_div = (item_reg.opcode == OP_EDGE) && capture_on_reg
                           && second_edge_reg && period_pos;
    assign status.div_done = div_done;

    assign div_dividend = numerator_reg;
    assign div_divisor  = {16'd0, period[15:0]};

    fptm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        pwm_top_next     = pwm_top_reg;
        timer_top_next   = timer_top_reg;
        numerator_next   = numerator_reg;
        limit_next       = limit_reg;
        interval_next    = interval_reg;
        report_next      = report_reg;
        running_next     = running_reg;
        duty_next        = duty_reg;
        self_test_next   = self_test_reg;
        capture_on_next  = capture_on_reg;
        second_edge_next = second_edge_reg;
        first_stamp_next = first_stamp_reg;
        freq_next        = freq_reg;
        mark_next        = mark_reg;
        alarm_next       = alarm_reg;

        if (cfg_wr) begin
            case (cfg_idx)
                REG_PWM_TOP:        pwm_top_next   = pwdata[15:0];
                REG_TIMER_TOP:      timer_top_next = pwdata[15:0];
                REG_NUMERATOR:      numerator_next = pwdata;
                REG_STALL_LIMIT:    limit_next     = pwdata;
                REG_ALARM_INTERVAL: interval_next  = pwdata;
                REG_REPORT_ENABLE: begin
                    report_next     = pwdata[0];
                    capture_on_next = pwdata[0];
                end
                default: ;
            endcase
        end

        if (cmd.exec) begin
            alarm_next = 1'b0;
            case (item_reg.opcode)
                OP_TEMP: begin
                    if (!self_test_reg) begin
                        if (temp_below || item_reg.temp_invalid) begin
                            running_next = 1'b0;
                        end else if (temp_above) begin
                            running_next = 1'b1;
                            duty_next    = pwm_top_reg;
                        end
                    end
                end
                OP_EDGE: begin
                    if (capture_on_reg) begin
                        if (!second_edge_reg) begin
                            first_stamp_next = item_reg.capture_value;
                            second_edge_next = 1'b1;
                        end else if (!period_pos) begin
                            freq_next        = 32'hFFFF_FFFF;
                            second_edge_next = 1'b0;
                        end
                    end
                end
                OP_STALL: begin
                    mark_next = mark_base;
                    if (running_reg) begin
                        if (freq_reg < limit_reg) begin
                            if ((item_reg.now_ms - mark_base) > interval_reg) begin
                                mark_next  = item_reg.now_ms;
                                alarm_next = 1'b1;
                            end
                        end else begin
                            mark_next = item_reg.now_ms;
                        end
                        freq_next = '0;
                    end
                end
                OP_TEST_ON: begin
                    self_test_next  = 1'b1;
                    freq_next       = '0;
                    capture_on_next = 1'b1;
                    running_next    = 1'b1;
                    duty_next       = pwm_top_reg;
                end
                OP_TEST_OFF: self_test_next = 1'b0;
                default: ;
            endcase
        end

        if (cmd.curve_write) begin
            running_next = 1'b1;
            duty_next    = curve_prod[36:21];
        end

        if (cmd.div_write) begin
            freq_next        = div_quotient;
            second_edge_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_top_reg     <= PWM_TOP_RESET;
            timer_top_reg   <= TIMER_TOP_RESET;
            numerator_reg   <= NUMERATOR_RESET;
            limit_reg       <= STALL_LIMIT_RESET;
            interval_reg    <= INTERVAL_RESET;
            report_reg      <= 1'b1;
            running_reg     <= 1'b1;
            duty_reg        <= DUTY_RESET;
            self_test_reg   <= 1'b0;
            capture_on_reg  <= 1'b1;
            second_edge_reg <= 1'b0;
            first_stamp_reg <= '0;
            freq_reg        <= '0;
            mark_reg        <= '0;
            alarm_reg       <= 1'b0;
        end else begin
            pwm_top_reg     <= pwm_top_next;
            timer_top_reg   <= timer_top_next;
            numerator_reg   <= numerator_next;
            limit_reg       <= limit_next;
            interval_reg    <= interval_next;
            report_reg      <= report_next;
            running_reg     <= running_next;
            duty_reg        <= duty_next;
            self_test_reg   <= self_test_next;
            capture_on_reg  <= capture_on_next;
            second_edge_reg <= second_edge_next;
            first_stamp_reg <= first_stamp_next;
            freq_reg        <= freq_next;
            mark_reg        <= mark_next;
            alarm_reg       <= alarm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            prod_reg <= prod;
        end
        if (cmd.out_load) begin
            out_reg.fan_enable       <= running_reg;
            out_reg.pwm_compare      <= duty_reg;
            out_reg.tach_freq        <= freq_reg;
            out_reg.stall_alarm      <= alarm_reg;
            out_reg.self_test_active <= self_test_reg;
        end
    end

    assign m_data = out_reg;

    always_comb begin
        case (cfg_idx)
            REG_PWM_TOP:        prdata = {16'd0, pwm_top_reg};
            REG_TIMER_TOP:      prdata = {16'd0, timer_top_reg};
            REG_NUMERATOR:      prdata = numerator_reg;
            REG_STALL_LIMIT:    prdata = limit_reg;
            REG_ALARM_INTERVAL: prdata = interval_reg;
            REG_REPORT_ENABLE:  prdata = {31'd0, report_reg};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/fptm_ctrl.sv
// ----------------------------------------------------------------------------
// fptm_ctrl
// Controller: sequences load, execute, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module fptm_ctrl
    import fptm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.need_mul) begin
                    state_next = ST_MUL;
                end else if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                cmd.curve_write = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.div_write = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/fptm_checker.sv
// ----------------------------------------------------------------------------
// fptm_checker
// Port-level checks of the fan monitor, bound to the top level.
// ----------------------------------------------------------------------------
module fptm_checker
    import fptm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data,
    input logic      pready
);
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in work");

    a_test_runs_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.self_test_active |-> m_data.fan_enable)
        else $error("fan stopped during self-test");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind fan_temperature_pwm_tach_monitor_unit fptm_checker u_fptm_checker (.*);
